// File: rtl/bfa_pkg.sv
// bitmap frame allocator: shared package
// constants, status and function codes, config indexes and the find result struct
// no dependencies
package bfa_pkg;

    localparam int DEF_MAX_FRAMES    = 32768;
    localparam int DEF_MAP_WORD_BITS = 64;

    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 1;
    localparam int IDX_W   = 15;
    localparam int POS_W   = 6;

    localparam logic [CFG_W-1:0] MANAGED_RST = 16'd32768;
    localparam logic [CFG_W-1:0] FIRST_RST   = 16'd256;

    localparam logic [CFG_IDX_W-1:0] CFG_MANAGED = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST   = 1'b1;

    localparam logic FN_ALLOC = 1'b0;
    localparam logic FN_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_FRAME = 2'd1,
        ST_RANGE    = 2'd2
    } t_status;

    typedef struct packed {
        logic             hit;
        logic [POS_W-1:0] pos;
    } t_find;

endpackage

// File: rtl/bfa_find.sv
// bitmap frame allocator: lowest set bit finder over one map word
// depends on bfa_pkg
module bfa_find import bfa_pkg::*; #(
    parameter int WORD_BITS = DEF_MAP_WORD_BITS
) (
    input  logic [WORD_BITS-1:0] i_vec,
    output t_find                o_res
);

    always_comb begin
        o_res.hit = |i_vec;
        o_res.pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (i_vec[i]) begin
                o_res.pos = POS_W'(i);
            end
        end
    end

endmodule

// File: rtl/bitmap_frame_allocator_top.sv
// bitmap frame allocator: top level, used bitmap in one synchronous memory
// depends on bfa_pkg and bfa_find
//
//  channel  | direction | handshake                | payload
//  in       | to block  | i_in_valid / o_in_stall  | i_func, i_frame_index
//  out      | from block| o_out_valid / i_out_stall| o_status, o_granted_index,
//           |           |                          | o_used_frames, o_free_frames
//  cfg      | to block  | i_cfg_we                 | i_cfg_index, i_cfg_data
//
// one item at a time; an allocate runs the word-wise memory read loop until a
// free bit is found, a free reads the word and clears the frame's bit, and a
// rejected item goes straight to the result; after reset the map is cleared one
// word per cycle while o_in_stall is high; configuration writes are taken throughout
// a result waits in the output register; the next item is taken meanwhile and
// its result waits internally until the output register frees up
module bitmap_frame_allocator_top import bfa_pkg::*; #(
    parameter int MAX_FRAMES    = DEF_MAX_FRAMES,
    parameter int MAP_WORD_BITS = DEF_MAP_WORD_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_func,
    input  logic [IDX_W-1:0]     i_frame_index,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [1:0]           o_status,
    output logic [IDX_W-1:0]     o_granted_index,
    output logic [CFG_W-1:0]     o_used_frames,
    output logic [CFG_W-1:0]     o_free_frames,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int WB        = MAP_WORD_BITS;
    localparam int WSH       = $clog2(WB);
    localparam int MAP_WORDS = (MAX_FRAMES + WB - 1) / WB;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int FW        = $clog2(MAX_FRAMES + 1);
    localparam int CW        = (FW > CFG_W) ? FW : CFG_W;
    localparam int WW        = CW - WSH;

    typedef enum logic [4:0] {
        S_CLR  = 5'b00001,
        S_IDLE = 5'b00010,
        S_ACHK = 5'b00100,
        S_FWR  = 5'b01000,
        S_RESP = 5'b10000
    } t_state;

    t_state             r_state, n_state;
    logic [AW-1:0]      r_clr, n_clr;
    logic [CFG_W-1:0]   r_managed, r_first;
    logic [WW-1:0]      r_word, n_word;
    logic               r_lead, n_lead;
    logic [WSH-1:0]     r_fbit, n_fbit;
    logic [CW-1:0]      r_count, n_count;
    t_status            r_pstat, n_pstat;
    logic [IDX_W-1:0]   r_pgrant, n_pgrant;
    logic [WB-1:0]      r_rdata;
    logic               r_out_valid;
    t_status            r_status;
    logic [IDX_W-1:0]   r_grant;
    logic [CFG_W-1:0]   r_used, r_free;

    logic [WB-1:0]      r_mem [MAP_WORDS];

    logic               mem_we, mem_re;
    logic [AW-1:0]      mem_wa, mem_ra;
    logic [WB-1:0]      mem_wd;

    logic               in_acc, out_free, load;
    logic [CW-1:0]      managed_c, lim, start_c, idx_c, free_c, grant_full;
    logic [WW-1:0]      lim_word, word_inc;
    logic [WSH-1:0]     lim_bit;
    logic [CW:0]        next_base;
    logic [WB-1:0]      lo_mask, hi_mask, free_vec;
    t_find              fres;

    assign in_acc    = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);

    assign managed_c = CW'(r_managed);
    assign start_c   = CW'(r_first);
    assign idx_c     = CW'(i_frame_index);
    assign lim       = (managed_c > CW'(MAX_FRAMES)) ? CW'(MAX_FRAMES) : managed_c;
    assign lim_word  = lim[CW-1:WSH];
    assign lim_bit   = lim[WSH-1:0];
    assign word_inc  = r_word + WW'(1);
    assign next_base = {1'b0, word_inc, {WSH{1'b0}}};
    assign free_c    = (lim > r_count) ? (lim - r_count) : '0;

    // candidate free bits of the word under scan
    assign lo_mask  = r_lead ? ({WB{1'b1}} << r_first[WSH-1:0]) : {WB{1'b1}};
    assign hi_mask  = (r_word == lim_word) ? ~({WB{1'b1}} << lim_bit) : {WB{1'b1}};
    assign free_vec = ~r_rdata & lo_mask & hi_mask;

    bfa_find #(
        .WORD_BITS (WB)
    ) u_find (
        .i_vec (free_vec),
        .o_res (fres)
    );

    assign grant_full = {r_word, fres.pos[WSH-1:0]};

    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_word   = r_word;
        n_lead   = r_lead;
        n_fbit   = r_fbit;
        n_count  = r_count;
        n_pstat  = r_pstat;
        n_pgrant = r_pgrant;
        mem_we   = 1'b0;
        mem_wa   = '0;
        mem_wd   = '0;
        mem_re   = 1'b0;
        mem_ra   = '0;
        load     = 1'b0;
        case (r_state)
            S_CLR: begin
                mem_we = 1'b1;
                mem_wa = r_clr;
                n_clr  = r_clr + AW'(1);
                if (r_clr == AW'(MAP_WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    if (i_func == FN_ALLOC) begin
                        if (start_c >= lim) begin
                            n_pstat  = ST_NO_FRAME;
                            n_pgrant = '0;
                            n_state  = S_RESP;
                        end else begin
                            mem_re  = 1'b1;
                            mem_ra  = start_c[WSH +: AW];
                            n_word  = start_c[CW-1:WSH];
                            n_lead  = 1'b1;
                            n_state = S_ACHK;
                        end
                    end else begin
                        if (idx_c >= lim) begin
                            n_pstat  = ST_RANGE;
                            n_pgrant = '0;
                            n_state  = S_RESP;
                        end else begin
                            mem_re  = 1'b1;
                            mem_ra  = idx_c[WSH +: AW];
                            n_word  = idx_c[CW-1:WSH];
                            n_fbit  = idx_c[WSH-1:0];
                            n_state = S_FWR;
                        end
                    end
                end
            end
            S_ACHK: begin
                if (fres.hit) begin
                    mem_we   = 1'b1;
                    mem_wa   = r_word[AW-1:0];
                    mem_wd   = r_rdata | (WB'(1) << fres.pos[WSH-1:0]);
                    n_count  = r_count + CW'(1);
                    n_pstat  = ST_OK;
                    n_pgrant = grant_full[IDX_W-1:0];
                    n_state  = S_RESP;
                end else if (next_base >= {1'b0, lim}) begin
                    n_pstat  = ST_NO_FRAME;
                    n_pgrant = '0;
                    n_state  = S_RESP;
                end else begin
                    mem_re = 1'b1;
                    mem_ra = word_inc[AW-1:0];
                    n_word = word_inc;
                    n_lead = 1'b0;
                end
            end
            S_FWR: begin
                if (r_rdata[r_fbit]) begin
                    mem_we  = 1'b1;
                    mem_wa  = r_word[AW-1:0];
                    mem_wd  = r_rdata & ~(WB'(1) << r_fbit);
                    n_count = r_count - CW'(1);
                end
                n_pstat  = ST_OK;
                n_pgrant = '0;
                n_state  = S_RESP;
            end
            S_RESP: begin
                if (out_free) begin
                    load    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLR;
                n_clr   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_clr     <= '0;
            r_count   <= '0;
            r_managed <= MANAGED_RST;
            r_first   <= FIRST_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_count <= n_count;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MANAGED: r_managed <= i_cfg_data;
                    CFG_FIRST:   r_first   <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_word   <= n_word;
        r_lead   <= n_lead;
        r_fbit   <= n_fbit;
        r_pstat  <= n_pstat;
        r_pgrant <= n_pgrant;
        if (load) begin
            r_status <= r_pstat;
            r_grant  <= r_pgrant;
            r_used   <= r_count[CFG_W-1:0];
            r_free   <= free_c[CFG_W-1:0];
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_granted_index = r_grant;
    assign o_used_frames   = r_used;
    assign o_free_frames   = r_free;

endmodule

// File: rtl/bfa_checker.sv
// bitmap frame allocator: port-level checker and its bind to the top level
// depends on bfa_pkg and bitmap_frame_allocator_top
module bfa_checker import bfa_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input logic                 i_func,
    input logic [IDX_W-1:0]     i_frame_index,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input logic [1:0]           o_status,
    input logic [IDX_W-1:0]     o_granted_index,
    input logic [CFG_W-1:0]     o_used_frames,
    input logic [CFG_W-1:0]     o_free_frames,
    input logic                 i_cfg_we,
    input logic [CFG_IDX_W-1:0] i_cfg_index,
    input logic [CFG_W-1:0]     i_cfg_data
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status)
            && $stable(o_granted_index) && $stable(o_used_frames)
            && $stable(o_free_frames))
        else $error("stalled result changed");

    // failed requests grant nothing
    a_no_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_NO_FRAME || o_status == ST_RANGE)
            |-> o_granted_index == '0)
        else $error("grant on failed request");

    // one item in flight
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second item taken while busy");

    // reset starts the clearing pass with no result pending
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall && !o_out_valid)
        else $error("block not held after reset");

endmodule

bind bitmap_frame_allocator_top bfa_checker u_bfa_checker (.*);
